// File: src/rbct_pkg.sv
// shared types and constants for the red blob centroid tracker
package rbct_pkg;

    localparam logic [2:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_DEADZONE       = 3'd2;
    localparam logic [2:0] CFG_AREA_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_YAW_GAIN       = 3'd4;
    localparam logic [2:0] CFG_PITCH_GAIN     = 3'd5;
    localparam logic [2:0] CFG_SATURATION_MIN = 3'd6;
    localparam logic [2:0] CFG_VALUE_MIN      = 3'd7;

    localparam int CNT_W = 23;
    localparam int SUM_W = 34;

    // frame summary handed from the front end to the back end
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] column_sum;
        logic [SUM_W-1:0] row_sum;
        logic [11:0]      width;
        logic [11:0]      height;
        logic [19:0]      yaw_pos;
        logic [19:0]      pitch_pos;
    } frame_sum_t;

endpackage

// File: src/rbct_front.sv
// pixel front end: hsv red test over a two stage pipe, counters and sums
module rbct_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic [11:0]          frame_width,
    input  logic [11:0]          frame_height,
    input  logic [7:0]           saturation_min,
    input  logic [7:0]           value_min,
    input  logic signed [19:0]   yaw_position,
    input  logic signed [19:0]   pitch_position,
    output logic                 sum_valid,
    input  logic                 sum_ready,
    output rbct_pkg::frame_sum_t sum_data
);
    import rbct_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // stage one: max, max minus min, hue numerator and offset
    logic [7:0]  v_reg, d_reg;
    logic signed [17:0] tot_reg;
    logic        s1_valid_reg;
    logic [CW-1:0] col1_reg;
    logic [RW-1:0] row1_reg;
    logic        last1_reg;
    logic [11:0] w1_reg, h1_reg;
    logic [19:0] yaw1_reg, pitch1_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [11:0]   w_c, h_c;
    logic          col_end, row_end;

    // clamp frame size
    always_comb
    begin
        if (frame_width == 12'd0) w_c = 12'd1;
        else if ({20'd0, frame_width} > MAX_WIDTH) w_c = 12'(MAX_WIDTH);
        else w_c = frame_width;
        if (frame_height == 12'd0) h_c = 12'd1;
        else if ({20'd0, frame_height} > MAX_HEIGHT) h_c = 12'(MAX_HEIGHT);
        else h_c = frame_height;
        col_end = (13'(col_reg) + 13'd1) >= {1'b0, w_c};
        row_end = (13'(row_reg) + 13'd1) >= {1'b0, h_c};
    end

    logic [7:0] vmax, vmin;
    logic signed [17:0] tot_c;
    always_comb
    begin
        logic [7:0] d;
        vmax = red;
        if (green > vmax) vmax = green;
        if (blue > vmax) vmax = blue;
        vmin = red;
        if (green < vmin) vmin = green;
        if (blue < vmin) vmin = blue;
        d = vmax - vmin;
        if (vmax == red)
            tot_c = 18'sd30 * ($signed({10'd0, green}) - $signed({10'd0, blue}));
        else if (vmax == green)
            tot_c = 18'sd60 * $signed({10'd0, d})
                  + 18'sd30 * ($signed({10'd0, blue}) - $signed({10'd0, red}));
        else
            tot_c = 18'sd120 * $signed({10'd0, d})
                  + 18'sd30 * ($signed({10'd0, red}) - $signed({10'd0, green}));
        if (tot_c < 0) tot_c = tot_c + 18'sd180 * $signed({10'd0, d});
    end

    // stage two: compare against thresholds without dividing
    // s >= smin  <=> 510d+v >= 2v*smin ; h bounds checked by cross multiply
    logic red_c;
    always_comb
    begin
        logic [19:0] sl, sr;
        logic [19:0] t2;
        logic [19:0] dd;
        logic lo_ok, hi_ok, s_ok, h_ok;
        sl = 20'd510 * {12'd0, d_reg} + {12'd0, v_reg};
        sr = 20'd2 * {12'd0, v_reg} * {12'd0, saturation_min};
        s_ok = (v_reg == 8'd0) ? (saturation_min == 8'd0) : (sl >= sr);
        t2 = 20'(2 * tot_reg) + {12'd0, d_reg};
        dd = {12'd0, d_reg};
        // h = floor(t2/(2d)); h<=10 <=> t2 < 22d ; h>=170 <=> t2 >= 340d
        // h 180 wraps to 0 which is also <= 10
        lo_ok = t2 < 20'd22 * dd;
        hi_ok = (t2 >= 20'd340 * dd) && (t2 < 20'd360 * dd);
        h_ok = (d_reg == 8'd0) || lo_ok || hi_ok || (t2 >= 20'd360 * dd);
        red_c = h_ok && s_ok && (v_reg >= value_min);
    end

    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] csum_reg, rsum_reg;
    logic             out_valid_reg;
    frame_sum_t       out_reg;

    assign pix_ready = !out_valid_reg || sum_ready;
    logic take;
    assign take = pix_valid && pix_ready;

    // raster counters and stage one register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ready) s1_valid_reg <= take;
            if (take)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
        end
    end

    // positions are captured with each pixel so the frame end sees its own
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            v_reg      <= vmax;
            d_reg      <= vmax - vmin;
            tot_reg    <= tot_c;
            col1_reg   <= col_reg;
            row1_reg   <= row_reg;
            last1_reg  <= col_end && row_end;
            w1_reg     <= w_c;
            h1_reg     <= h_c;
            yaw1_reg   <= yaw_position;
            pitch1_reg <= pitch_position;
        end
    end

    // accumulate and hand off the frame summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_ready) out_valid_reg <= 1'b0;
            if (s1_valid_reg && pix_ready)
            begin
                logic [CNT_W-1:0] c_n;
                logic [SUM_W-1:0] cs_n, rs_n;
                c_n  = cnt_reg + CNT_W'(red_c);
                cs_n = csum_reg + (red_c ? SUM_W'(col1_reg) : '0);
                rs_n = rsum_reg + (red_c ? SUM_W'(row1_reg) : '0);
                if (last1_reg)
                begin
                    out_valid_reg      <= 1'b1;
                    out_reg.count      <= c_n;
                    out_reg.column_sum <= cs_n;
                    out_reg.row_sum    <= rs_n;
                    out_reg.width      <= w1_reg;
                    out_reg.height     <= h1_reg;
                    out_reg.yaw_pos    <= yaw1_reg;
                    out_reg.pitch_pos  <= pitch1_reg;
                    cnt_reg  <= '0;
                    csum_reg <= '0;
                    rsum_reg <= '0;
                end
                else
                begin
                    cnt_reg  <= c_n;
                    csum_reg <= cs_n;
                    rsum_reg <= rs_n;
                end
            end
        end
    end

    assign sum_valid = out_valid_reg;
    assign sum_data  = out_reg;
endmodule

// File: src/rbct_back.sv
// back end: found test, serial division, deadzone, target math, result register
module rbct_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sum_valid,
    output logic                 sum_ready,
    input  rbct_pkg::frame_sum_t sum_data,
    input  logic [11:0]          deadzone_pixels,
    input  logic [29:0]          area_threshold,
    input  logic [23:0]          yaw_gain,
    input  logic [23:0]          pitch_gain,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 blob_found,
    output logic [10:0]          centroid_x,
    output logic [10:0]          centroid_y,
    output logic signed [12:0]   error_x,
    output logic signed [12:0]   error_y,
    output logic signed [19:0]   yaw_cmd,
    output logic signed [19:0]   pitch_cmd,
    output logic                 send_command
);
    import rbct_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_TGT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       state_reg;
    logic [5:0]       step_reg;
    frame_sum_t       f_reg;
    logic             found_reg;
    logic [SUM_W-1:0] qx_reg, qy_reg;
    logic [CNT_W:0]   rx_reg, ry_reg;
    logic signed [12:0] ex_reg, ey_reg;
    logic signed [37:0] px_reg, py_reg;

    assign sum_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    function automatic logic signed [12:0] dz(input logic signed [12:0] e,
                                               input logic [11:0] z);
        logic [12:0] a;
        a = e[12] ? 13'(-e) : 13'(e);
        dz = (a < {1'b0, z}) ? 13'sd0 : e;
    endfunction

    function automatic logic signed [19:0] tgt(input logic signed [19:0] pos,
                                                input logic signed [37:0] dq);
        logic signed [39:0] t;
        t = ({{20{pos[19]}}, pos} <<< 8) + 40'(dq) + 40'sd128;
        t = t >>> 8;
        if (t > 40'sd524287) tgt = 20'sd524287;
        else if (t < -40'sd524288) tgt = -20'sd524288;
        else tgt = t[19:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (sum_valid)
                    begin
                        f_reg     <= sum_data;
                        found_reg <= ({sum_data.count, 8'd0} - 31'(sum_data.count))
                                     > {1'b0, area_threshold};
                        qx_reg    <= sum_data.column_sum;
                        qy_reg    <= sum_data.row_sum;
                        rx_reg    <= '0;
                        ry_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                // restoring division, one quotient bit a cycle
                ST_DIV:
                begin
                    logic [CNT_W:0] tx, ty;
                    tx = {rx_reg[CNT_W-1:0], qx_reg[SUM_W-1]};
                    ty = {ry_reg[CNT_W-1:0], qy_reg[SUM_W-1]};
                    if (tx >= {1'b0, f_reg.count})
                    begin
                        rx_reg <= tx - {1'b0, f_reg.count};
                        qx_reg <= {qx_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rx_reg <= tx;
                        qx_reg <= {qx_reg[SUM_W-2:0], 1'b0};
                    end
                    if (ty >= {1'b0, f_reg.count})
                    begin
                        ry_reg <= ty - {1'b0, f_reg.count};
                        qy_reg <= {qy_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        ry_reg <= ty;
                        qy_reg <= {qy_reg[SUM_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(SUM_W - 1)) state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    if (found_reg)
                    begin
                        ex_reg <= dz(13'($signed({2'b0, f_reg.width[11:1]}))
                                   - $signed({2'b0, qx_reg[10:0]}), deadzone_pixels);
                        ey_reg <= dz(13'($signed({2'b0, f_reg.height[11:1]}))
                                   - $signed({2'b0, qy_reg[10:0]}), deadzone_pixels);
                    end
                    else
                    begin
                        ex_reg <= '0;
                        ey_reg <= '0;
                        qx_reg <= '0;
                        qy_reg <= '0;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    px_reg <= ex_reg * $signed({1'b0, yaw_gain});
                    py_reg <= -(ey_reg * $signed({1'b0, pitch_gain}));
                    state_reg <= ST_TGT;
                end
                ST_TGT:
                begin
                    blob_found   <= found_reg;
                    centroid_x   <= qx_reg[10:0];
                    centroid_y   <= qy_reg[10:0];
                    error_x      <= ex_reg;
                    error_y      <= ey_reg;
                    yaw_cmd      <= tgt($signed(f_reg.yaw_pos), px_reg);
                    pitch_cmd    <= tgt($signed(f_reg.pitch_pos), py_reg);
                    send_command <= found_reg && (ex_reg != 0 || ey_reg != 0);
                    state_reg    <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: src/red_blob_centroid_tracker.sv
// top level of the red blob centroid tracker
//
// channel  signals                              direction
// in       in_valid/in_ready, action..pitch      to block
// cfg      cfg_valid/cfg_ready, cfg_index/data   to block
// out      out_valid/out_ready, blob_found..     from block
//
// one pixel beat per cycle, unless the front end is stalled, through a two stage classify pipe in the front end
// frame summaries queue in one register; the back end takes a new summary only once
// its last result is taken, and runs each frame through the 34 step serial divider
// reset clears counters, sums, positions and restores register defaults
// a pending result stalls the front end only once a second frame is finished
module red_blob_centroid_tracker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  logic               yaw_present,
    input  logic signed [19:0] measured_yaw,
    input  logic               pitch_present,
    input  logic signed [19:0] measured_pitch,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [29:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               blob_found,
    output logic [10:0]        centroid_x,
    output logic [10:0]        centroid_y,
    output logic signed [12:0] error_x,
    output logic signed [12:0] error_y,
    output logic signed [19:0] yaw_cmd,
    output logic signed [19:0] pitch_cmd,
    output logic               send_command
);
    import rbct_pkg::*;

    logic [11:0] fw_reg, fh_reg, dz_reg;
    logic [29:0] at_reg;
    logic [23:0] yg_reg, pg_reg;
    logic [7:0]  smin_reg, vmin_reg;
    logic signed [19:0] yaw_reg, pitch_reg;

    logic       pix_ready, sum_valid, sum_ready;
    frame_sum_t sum_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = action ? 1'b1 : pix_ready;

    // configuration registers and joint positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= 12'd640;
            fh_reg    <= 12'd480;
            dz_reg    <= 12'd20;
            at_reg    <= 30'd1000;
            yg_reg    <= 24'd8389;
            pg_reg    <= 24'd4194;
            smin_reg  <= 8'd120;
            vmin_reg  <= 8'd70;
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:    fw_reg   <= cfg_data[11:0];
                    CFG_FRAME_HEIGHT:   fh_reg   <= cfg_data[11:0];
                    CFG_DEADZONE:       dz_reg   <= cfg_data[11:0];
                    CFG_AREA_THRESHOLD: at_reg   <= cfg_data;
                    CFG_YAW_GAIN:       yg_reg   <= cfg_data[23:0];
                    CFG_PITCH_GAIN:     pg_reg   <= cfg_data[23:0];
                    CFG_SATURATION_MIN: smin_reg <= cfg_data[7:0];
                    CFG_VALUE_MIN:      vmin_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && action)
            begin
                if (yaw_present) yaw_reg <= measured_yaw;
                if (pitch_present) pitch_reg <= measured_pitch;
            end
        end
    end

    rbct_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(in_valid && !action), .pix_ready(pix_ready),
        .red(red), .green(green), .blue(blue),
        .frame_width(fw_reg), .frame_height(fh_reg),
        .saturation_min(smin_reg), .value_min(vmin_reg),
        .yaw_position(yaw_reg), .pitch_position(pitch_reg),
        .sum_valid(sum_valid), .sum_ready(sum_ready), .sum_data(sum_data)
    );

    rbct_back u_back (
        .clk(clk), .rst_n(rst_n),
        .sum_valid(sum_valid), .sum_ready(sum_ready), .sum_data(sum_data),
        .deadzone_pixels(dz_reg), .area_threshold(at_reg),
        .yaw_gain(yg_reg), .pitch_gain(pg_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .blob_found(blob_found), .centroid_x(centroid_x), .centroid_y(centroid_y),
        .error_x(error_x), .error_y(error_y),
        .yaw_cmd(yaw_cmd), .pitch_cmd(pitch_cmd),
        .send_command(send_command)
    );

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(yaw_cmd) && $stable(error_x))
        else $error("result changed while stalled");

    // command only with a found blob
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_command |-> blob_found)
        else $error("command without blob");

    // no blob means zero errors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !blob_found |-> error_x == 0 && error_y == 0)
        else $error("error without blob");
endmodule

// File: tb/tb_red_blob_centroid_tracker.sv
// testbench for the red blob centroid tracker: random pixel frames and joint updates
`timescale 1ns / 1ps

module tb_red_blob_centroid_tracker;
    import rbct_pkg::*;

    localparam int SIZE_LIMIT = 2048;

    typedef struct {
        logic               action;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic               yaw_present;
        logic signed [19:0] measured_yaw;
        logic               pitch_present;
        logic signed [19:0] measured_pitch;
    } beat_t;

    typedef struct {
        logic               blob_found;
        logic [10:0]        centroid_x;
        logic [10:0]        centroid_y;
        logic signed [12:0] error_x;
        logic signed [12:0] error_y;
        logic signed [19:0] yaw_cmd;
        logic signed [19:0] pitch_cmd;
        logic               send_command;
    } frame_result_t;

    // tracks frame accumulation and holds expected per-frame results
    class centroid_scoreboard;
        int unsigned   width_reg, height_reg, deadzone_reg, threshold_reg;
        int unsigned   yaw_gain_reg, pitch_gain_reg, sat_min_reg, val_min_reg;
        longint        yaw_pos, pitch_pos;
        int unsigned   col, row;
        longint        red_count, col_sum, row_sum;
        frame_result_t expected_frames[$];
        int            fails;
        int            frames_seen;

        function new();
            width_reg = 640; height_reg = 480; deadzone_reg = 20;
            threshold_reg = 1000; yaw_gain_reg = 8389; pitch_gain_reg = 4194;
            sat_min_reg = 120; val_min_reg = 70;
            yaw_pos = 0; pitch_pos = 0; col = 0; row = 0;
            red_count = 0; col_sum = 0; row_sum = 0;
            fails = 0; frames_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [29:0] data);
            case (idx)
                CFG_FRAME_WIDTH:    width_reg = data[11:0];
                CFG_FRAME_HEIGHT:   height_reg = data[11:0];
                CFG_DEADZONE:       deadzone_reg = data[11:0];
                CFG_AREA_THRESHOLD: threshold_reg = data;
                CFG_YAW_GAIN:       yaw_gain_reg = data[23:0];
                CFG_PITCH_GAIN:     pitch_gain_reg = data[23:0];
                CFG_SATURATION_MIN: sat_min_reg = data[7:0];
                default:            val_min_reg = data[7:0];
            endcase
        endfunction

        static function int unsigned clamp_size(int unsigned v);
            if (v == 0) return 1;
            if (v > SIZE_LIMIT) return SIZE_LIMIT;
            return v;
        endfunction

        // hsv test in half degrees, rounded half up, hue 180 wraps to 0
        function bit pixel_is_red(int r, int g, int b);
            int     v, m, d, s, h;
            longint ofs, num, tot;
            v = r; m = r; s = 0; h = 0;
            if (g > v) v = g;
            if (b > v) v = b;
            if (g < m) m = g;
            if (b < m) m = b;
            d = v - m;
            if (v != 0) s = (510 * d + v) / (2 * v);
            if (d != 0) begin
                if (v == r) begin ofs = 0; num = g - b; end
                else if (v == g) begin ofs = 60; num = b - r; end
                else begin ofs = 120; num = r - g; end
                tot = ofs * d + 30 * num;
                if (tot < 0) tot += 180 * d;
                h = int'((2 * tot + d) / (2 * d));
                if (h >= 180) h -= 180;
            end
            return (h <= 10 || h >= 170) && s >= sat_min_reg && v >= val_min_reg;
        endfunction

        function longint apply_deadzone(longint e);
            longint a;
            a = (e < 0) ? -e : e;
            return (a < deadzone_reg) ? 0 : e;
        endfunction

        // q.24 sum rounded half up to q4.16, saturated to 20 bits
        static function longint steer_target(longint pos, longint delta);
            longint t;
            t = (pos * 256 + delta + 128) >>> 8;
            if (t > 524287) t = 524287;
            if (t < -524288) t = -524288;
            return t;
        endfunction

        function void take_beat(beat_t b);
            int unsigned   w, hgt;
            bit            last;
            longint        cx, cy, ex, ey;
            frame_result_t res;
            w = clamp_size(width_reg);
            hgt = clamp_size(height_reg);
            cx = 0; cy = 0; ex = 0; ey = 0;
            if (b.action) begin
                if (b.yaw_present) yaw_pos = b.measured_yaw;
                if (b.pitch_present) pitch_pos = b.measured_pitch;
                return;
            end
            if (pixel_is_red(b.red, b.green, b.blue)) begin
                red_count++;
                col_sum += col;
                row_sum += row;
            end
            last = 0;
            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= hgt) begin row = 0; last = 1; end
                else row++;
            end else begin
                col++;
            end
            if (!last) return;
            res.blob_found = (red_count * 255 > longint'(threshold_reg));
            if (res.blob_found) begin
                cx = col_sum / red_count;
                cy = row_sum / red_count;
                ex = apply_deadzone(longint'(w / 2) - cx);
                ey = apply_deadzone(longint'(hgt / 2) - cy);
            end
            res.centroid_x = cx[10:0];
            res.centroid_y = cy[10:0];
            res.error_x = ex[12:0];
            res.error_y = ey[12:0];
            res.yaw_cmd = 20'(steer_target(yaw_pos, ex * yaw_gain_reg));
            res.pitch_cmd = 20'(steer_target(pitch_pos, -(ey * pitch_gain_reg)));
            res.send_command = res.blob_found && (ex != 0 || ey != 0);
            expected_frames.insert(expected_frames.size(), res);
            red_count = 0; col_sum = 0; row_sum = 0;
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                fails++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
            end
        endfunction

        function void match_result(frame_result_t act);
            frame_result_t exp_r;
            frames_seen++;
            if (expected_frames.size() == 0) begin
                fails++;
                $display("%0t: unexpected result, expected none, actual found=%0d cx=%0d",
                         $time, act.blob_found, act.centroid_x);
                return;
            end
            exp_r = expected_frames.pop_front();
            compare_field("blob_found", exp_r.blob_found, act.blob_found);
            compare_field("centroid_x", exp_r.centroid_x, act.centroid_x);
            compare_field("centroid_y", exp_r.centroid_y, act.centroid_y);
            compare_field("error_x", exp_r.error_x, act.error_x);
            compare_field("error_y", exp_r.error_y, act.error_y);
            compare_field("yaw_cmd", exp_r.yaw_cmd, act.yaw_cmd);
            compare_field("pitch_cmd", exp_r.pitch_cmd, act.pitch_cmd);
            compare_field("send_command", exp_r.send_command, act.send_command);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               yaw_present;
    logic signed [19:0] measured_yaw;
    logic               pitch_present;
    logic signed [19:0] measured_pitch;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [29:0]        cfg_data;
    logic               out_valid;
    logic               out_ready;
    logic               blob_found;
    logic [10:0]        centroid_x;
    logic [10:0]        centroid_y;
    logic signed [12:0] error_x;
    logic signed [12:0] error_y;
    logic signed [19:0] yaw_cmd;
    logic signed [19:0] pitch_cmd;
    logic               send_command;

    centroid_scoreboard sb;
    int                 beats_sent;
    int                 burst_left;
    int                 stall_mode;

    red_blob_centroid_tracker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .yaw_present    (yaw_present),
        .measured_yaw   (measured_yaw),
        .pitch_present  (pitch_present),
        .measured_pitch (measured_pitch),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .blob_found     (blob_found),
        .centroid_x     (centroid_x),
        .centroid_y     (centroid_y),
        .error_x        (error_x),
        .error_y        (error_y),
        .yaw_cmd        (yaw_cmd),
        .pitch_cmd      (pitch_cmd),
        .send_command   (send_command)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("red_blob_centroid_tracker test failed");
        $finish;
    end

    // receiver stall pattern, switching among four characters chosen at random
    always @(negedge clk)
    begin
        if (($time / 8) % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (($time / 8) % 8 < 5);
        endcase
    end

    // result beat monitor
    always @(posedge clk)
    begin
        frame_result_t act;
        if (rst_n && out_valid && out_ready) begin
            act.blob_found = blob_found;
            act.centroid_x = centroid_x;
            act.centroid_y = centroid_y;
            act.error_x = error_x;
            act.error_y = error_y;
            act.yaw_cmd = yaw_cmd;
            act.pitch_cmd = pitch_cmd;
            act.send_command = send_command;
            sb.match_result(act);
        end
    end

    // one input beat; valid stays high across a burst, random gaps before most bursts
    task automatic send_beat(beat_t b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid = 1'b1;
        action = b.action;
        blue = b.blue;
        green = b.green;
        red = b.red;
        yaw_present = b.yaw_present;
        measured_yaw = b.measured_yaw;
        pitch_present = b.pitch_present;
        measured_pitch = b.measured_pitch;
        do @(posedge clk); while (!in_ready);
        sb.take_beat(b);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [29:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // hold off until every expected frame is out, then let the back end settle
    task automatic drain();
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.expected_frames.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_all(int unsigned w, int unsigned h, int unsigned dz,
                             int unsigned thr, int unsigned yg, int unsigned pg,
                             int unsigned smin, int unsigned vmin);
        write_reg(CFG_FRAME_WIDTH, 30'(w));
        write_reg(CFG_FRAME_HEIGHT, 30'(h));
        write_reg(CFG_DEADZONE, 30'(dz));
        write_reg(CFG_AREA_THRESHOLD, 30'(thr));
        write_reg(CFG_YAW_GAIN, 30'(yg));
        write_reg(CFG_PITCH_GAIN, 30'(pg));
        write_reg(CFG_SATURATION_MIN, 30'(smin));
        write_reg(CFG_VALUE_MIN, 30'(vmin));
    endtask

    function automatic beat_t pixel(int r, int g, int b);
        beat_t p;
        p.action = 1'b0;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        p.yaw_present = 1'($urandom_range(0, 1));
        p.measured_yaw = 20'($urandom);
        p.pitch_present = 1'($urandom_range(0, 1));
        p.measured_pitch = 20'($urandom);
        return p;
    endfunction

    function automatic beat_t joint(bit yp, int yv, bit pp, int pv);
        beat_t j;
        j = pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        j.action = 1'b1;
        j.yaw_present = yp;
        j.measured_yaw = 20'(yv);
        j.pitch_present = pp;
        j.measured_pitch = 20'(pv);
        return j;
    endfunction

    // joint updates now and then, otherwise half reddish pixels so blobs form, half arbitrary colors
    function automatic beat_t random_beat();
        if ($urandom_range(0, 9) == 0)
            return joint($urandom_range(0, 1), $urandom, $urandom_range(0, 1), $urandom);
        if ($urandom_range(0, 1) == 0)
            return pixel($urandom_range(100, 255), $urandom_range(0, 60),
                         $urandom_range(0, 60));
        return pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    initial
    begin
        int phase;
        int count;
        sb = new();
        beats_sent = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        blue = '0;
        green = '0;
        red = '0;
        yaw_present = 1'b0;
        measured_yaw = '0;
        pitch_present = 1'b0;
        measured_pitch = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        out_ready = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        // directed: small frame, color extremes, hue wrap, joint extremes
        write_all(4, 2, 1, 254, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
        send_beat(joint(1, -524288, 1, 524287));
        send_beat(joint(0, 5, 0, 7));
        send_beat(pixel(0, 0, 0));
        send_beat(pixel(255, 255, 255));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(255, 0, 5));
        send_beat(pixel(0, 255, 0));
        send_beat(pixel(0, 0, 255));
        send_beat(pixel(128, 128, 128));
        send_beat(pixel(255, 40, 0));
        send_beat(joint(1, 524287, 1, -524288));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(200, 0, 90));
        send_beat(pixel(1, 0, 0));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(255, 0, 0));
        send_beat(pixel(255, 0, 0));
        drain();

        // random phases, some with extreme settings, some ending mid-frame
        for (phase = 0; phase < 16; phase++) begin
            case (phase)
                0: write_all(0, 0, 0, 0, 24'hFFFFFF, 0, 255, 255);
                1: write_all(4095, 1, 2048, 30'h3FFFFFFF, 0, 24'hFFFFFF, 0, 0);
                2: write_all(1, 4095, 0, 0, 8389, 4194, 120, 70);
                3: write_all(7, 5, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
                default: write_all($urandom_range(1, 12), $urandom_range(1, 10),
                                   $urandom_range(0, 6), $urandom_range(0, 3000),
                                   $urandom_range(0, 24'hFFFFFF),
                                   $urandom_range(0, 24'hFFFFFF),
                                   $urandom_range(0, 200), $urandom_range(0, 200));
            endcase
            count = $urandom_range(90, 140);
            repeat (count) send_beat(random_beat());
            drain();
        end

        $display("covered %0d input beats and %0d frame results over 17 register settings",
                 beats_sent, sb.frames_seen);
        if (sb.fails == 0 && sb.expected_frames.size() == 0)
            $display("red_blob_centroid_tracker test passed");
        else
            $display("red_blob_centroid_tracker test failed");
        $finish;
    end
endmodule
